@@ hdl/bpe_pkg.sv @@
// ----------------------------------------------------------------------------
// bpe_pkg - shared types and constants for the Bezier point evaluator
// Coordinate and parameter formats, command codes, sequencer states and the
// control word that runs down the interpolation pipeline.
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int COORD_W = 32;          // Q16.16 signed
    localparam int FRAC_W  = 16;          // fraction bits of t
    localparam int T_W     = 17;          // unsigned Q1.16, 1.0 included
    localparam int CNT_W   = 5;           // node_count register
    localparam int IDX_W   = 4;           // node_index field
    localparam int PROD_W  = COORD_W + 1 + T_W + 1;

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(4);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    // one memory read issued by the sequencer
    typedef struct packed {
        logic valid;
        logic first;   // level reads the node store
        logic load;    // leftmost point of a level, no lerp
        logic last;    // read that completes the final point
    } t_issue;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

@@ hdl/bpe_if.sv @@
// ----------------------------------------------------------------------------
// bpe_if - valid/ready channels of the Bezier point evaluator
// Input word, result word and configuration write channel.
// ----------------------------------------------------------------------------
interface bpe_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [bpe_pkg::IDX_W-1:0]            node_index;
    logic signed [bpe_pkg::COORD_W-1:0]   x_value;
    logic signed [bpe_pkg::COORD_W-1:0]   y_value;
    logic [bpe_pkg::T_W-1:0]              t_value;

    modport source (output valid, cmd, node_index, x_value, y_value, t_value,
                    input ready);
    modport sink   (input valid, cmd, node_index, x_value, y_value, t_value,
                    output ready);
endinterface

interface bpe_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bpe_pkg::COORD_W-1:0]   point_x;
    logic signed [bpe_pkg::COORD_W-1:0]   point_y;

    modport source (output valid, point_x, point_y, input ready);
    modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface bpe_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [bpe_pkg::CNT_W-1:0]            data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hdl/bpe_lerp.sv @@
// ----------------------------------------------------------------------------
// bpe_lerp - two-stage interpolation datapath
// Takes the streamed points of one level, forms a + (b - a) * t for x and y
// and hands the result back to the work memory or the result register.
// ----------------------------------------------------------------------------
module bpe_lerp #(
    parameter int AW = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpe_pkg::t_issue               i_issue,
    input  logic [AW-1:0]                 i_addr,
    input  logic [bpe_pkg::T_W-1:0]       i_t,
    input  bpe_pkg::t_point               i_node_rd,
    input  bpe_pkg::t_point               i_work_rd,
    output logic                          o_wr,
    output logic [AW-1:0]                 o_wr_addr,
    output bpe_pkg::t_point               o_wr_data,
    output logic                          o_res_valid,
    output bpe_pkg::t_point               o_res
);

    // stage 1: aligned with memory read data
    bpe_pkg::t_issue                     r_c1;
    logic [AW-1:0]                       r_addr1;
    bpe_pkg::t_point                     r_prev;

    // stage 2: product registered, add and write back
    logic                                r_v2;
    logic                                r_last2;
    logic [AW-1:0]                       r_waddr2;
    bpe_pkg::t_point                     r_a;
    logic signed [bpe_pkg::COORD_W-1:0]  r_qx;
    logic signed [bpe_pkg::COORD_W-1:0]  r_qy;

    bpe_pkg::t_point                     r_res;
    logic                                r_res_valid;

    bpe_pkg::t_point                     w_cur;
    logic signed [bpe_pkg::COORD_W:0]    w_dx;
    logic signed [bpe_pkg::COORD_W:0]    w_dy;
    logic signed [bpe_pkg::PROD_W-1:0]   w_px;
    logic signed [bpe_pkg::PROD_W-1:0]   w_py;
    logic signed [bpe_pkg::T_W:0]        w_ts;
    bpe_pkg::t_point                     w_sum;

    always_comb begin
        w_cur = r_c1.first ? i_node_rd : i_work_rd;
        w_dx  = {w_cur.x[bpe_pkg::COORD_W-1], w_cur.x}
              - {r_prev.x[bpe_pkg::COORD_W-1], r_prev.x};
        w_dy  = {w_cur.y[bpe_pkg::COORD_W-1], w_cur.y}
              - {r_prev.y[bpe_pkg::COORD_W-1], r_prev.y};
        w_ts  = $signed({1'b0, i_t});
        w_px  = w_dx * w_ts;
        w_py  = w_dy * w_ts;
        // low fraction bits dropped: floor of the product / 2^16
        w_sum.x = r_a.x + r_qx;
        w_sum.y = r_a.y + r_qy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1        <= '0;
            r_v2        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_c1        <= i_issue;
            r_v2        <= r_c1.valid && !r_c1.load;
            r_res_valid <= r_v2 && r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr1 <= i_addr;
        if (r_c1.valid) begin
            r_prev   <= w_cur;
            r_a      <= r_prev;
            r_last2  <= r_c1.last;
            r_waddr2 <= AW'(r_addr1 - 1'b1);
            r_qx     <= w_px[bpe_pkg::COORD_W+bpe_pkg::FRAC_W-1:bpe_pkg::FRAC_W];
            r_qy     <= w_py[bpe_pkg::COORD_W+bpe_pkg::FRAC_W-1:bpe_pkg::FRAC_W];
        end
        if (r_v2 && r_last2) begin
            r_res <= w_sum;
        end
    end

    assign o_wr        = r_v2;
    assign o_wr_addr   = r_waddr2;
    assign o_wr_data   = w_sum;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ hdl/bpe_seq.sv @@
// ----------------------------------------------------------------------------
// bpe_seq - level sequencer
// Walks the triangle level by level, one memory read per cycle outside
// ST_WAIT, and holds the finished point until the output register is free.
// ----------------------------------------------------------------------------
module bpe_seq #(
    parameter int AW = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [AW-1:0]         i_len,
    input  logic                  i_res_valid,
    input  logic                  i_out_free,
    output bpe_pkg::t_issue       o_issue,
    output logic [AW-1:0]         o_addr,
    output logic                  o_idle,
    output logic                  o_load
);

    localparam logic [AW:0] LenOne = (AW+1)'(1);
    localparam logic [AW:0] LenTwo = (AW+1)'(2);

    bpe_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_len, n_len;
    logic [AW-1:0]   r_k, n_k;
    logic            r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpe_pkg::ST_IDLE;
            r_len   <= '0;
            r_k     <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_k     <= n_k;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_k     = r_k;
        n_first = r_first;
        o_issue = '0;
        o_idle  = 1'b0;
        o_load  = 1'b0;
        case (r_state)
            bpe_pkg::ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_state = bpe_pkg::ST_RUN;
                    n_len   = i_len;
                    n_k     = '0;
                    n_first = 1'b1;
                end
            end
            bpe_pkg::ST_RUN: begin
                o_issue.valid = 1'b1;
                o_issue.first = r_first;
                o_issue.load  = (r_k == '0);
                o_issue.last  = ({1'b0, r_len} == LenOne) && (r_k == r_len);
                if (r_k == r_len) begin
                    n_k     = '0;
                    n_first = 1'b0;
                    n_len   = AW'(r_len - 1'b1);
                    if ({1'b0, r_len} == LenOne) begin
                        n_state = bpe_pkg::ST_DRAIN;
                    end else if ({1'b0, r_len} == LenTwo) begin
                        // last two writes still in flight
                        n_state = bpe_pkg::ST_WAIT;
                    end
                end else begin
                    n_k = AW'(r_k + 1'b1);
                end
            end
            bpe_pkg::ST_WAIT: begin
                n_state = bpe_pkg::ST_RUN;
            end
            bpe_pkg::ST_DRAIN: begin
                if (i_res_valid) begin
                    n_state = bpe_pkg::ST_DONE;
                end
            end
            bpe_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = bpe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bpe_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_addr = r_k;

    a_k_in_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpe_pkg::ST_RUN) |-> (r_k <= r_len))
        else $error("read index past end of level");

    a_res_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (r_state == bpe_pkg::ST_DRAIN))
        else $error("result arrived outside drain");

endmodule

@@ hdl/bezier_point_eval.sv @@
// ----------------------------------------------------------------------------
// bezier_point_eval - 2-D Bezier point evaluation by de Casteljau
// Operation: a write word stores one control point. An evaluate word over n
//   control points runs the triangle through the single read port of the
//   work memory, one read issued per cycle, with a wait bubble before the
//   last level except for n = 2, which needs none.
// Throughput: one word at a time; the next word is taken when the previous
//   result has moved into the output register.
// Reset: node_count goes to 4; node and work memories are not cleared.
// ----------------------------------------------------------------------------
module bezier_point_eval #(
    parameter int MAX_NODES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bpe_in_if.sink   i_in,
    bpe_out_if.source o_out,
    bpe_cfg_if.sink  i_cfg
);

    // address width of both memories
    localparam int AW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam logic [6:0] MaxN = 7'(MAX_NODES);

    // Node store: control points written by write words.
    // Work store: one row of the triangle, updated in place; entry j of a
    // level is overwritten only after entry j+1 of the previous one is read.
    bpe_pkg::t_point r_node_mem [MAX_NODES];
    bpe_pkg::t_point r_work_mem [MAX_NODES];
    bpe_pkg::t_point r_node_rd;
    bpe_pkg::t_point r_work_rd;

    logic [bpe_pkg::CNT_W-1:0] r_node_count;
    logic [bpe_pkg::T_W-1:0]   r_t;
    logic                      r_out_valid;
    bpe_pkg::t_point           r_out;

    logic                      w_in_acc;
    logic                      w_node_we;
    logic [AW-1:0]             w_node_waddr;
    logic                      w_start;
    logic [6:0]                w_cnt7;
    logic [6:0]                w_n;
    logic [AW-1:0]             w_len;
    logic                      w_out_free;

    bpe_pkg::t_issue           w_issue;
    logic [AW-1:0]             w_addr;
    logic                      w_idle;
    logic                      w_load;
    logic                      w_wr;
    logic [AW-1:0]             w_wr_addr;
    bpe_pkg::t_point           w_wr_data;
    logic                      w_res_valid;
    bpe_pkg::t_point           w_res;

    // ---- input side ------------------------------------------------------
    assign i_in.ready   = w_idle;
    assign w_in_acc     = i_in.valid && i_in.ready;
    // slots beyond the store are dropped
    assign w_node_we    = w_in_acc && (i_in.cmd == bpe_pkg::CMD_WRITE)
                       && (7'(i_in.node_index) < MaxN);
    assign w_node_waddr = AW'(i_in.node_index);
    assign w_start      = w_in_acc && (i_in.cmd == bpe_pkg::CMD_EVAL);

    // node_count clamped to [2, MAX_NODES]; a level count of n-1 lerps
    always_comb begin
        w_cnt7 = 7'(r_node_count);
        if (w_cnt7 < 7'd2) begin
            w_n = 7'd2;
        end else if (w_cnt7 > MaxN) begin
            w_n = MaxN;
        end else begin
            w_n = w_cnt7;
        end
        w_len = AW'(w_n - 7'd1);
    end

    // ---- configuration ---------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= bpe_pkg::NODE_COUNT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_node_count <= i_cfg.data;
        end
    end

    // t saturated at 1.0, held for the whole evaluation
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_t <= (i_in.t_value > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : i_in.t_value;
        end
    end

    // ---- memories, registered read port -------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_node_we) begin
            r_node_mem[w_node_waddr] <= {i_in.x_value, i_in.y_value};
        end
        r_node_rd <= r_node_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_work_mem[w_wr_addr] <= w_wr_data;
        end
        r_work_rd <= r_work_mem[w_addr];
    end

    // ---- sequencer and datapath ------------------------------------------
    bpe_seq #(
        .AW (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_len       (w_len),
        .i_res_valid (w_res_valid),
        .i_out_free  (w_out_free),
        .o_issue     (w_issue),
        .o_addr      (w_addr),
        .o_idle      (w_idle),
        .o_load      (w_load)
    );

    bpe_lerp #(
        .AW (AW)
    ) u_lerp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (w_issue),
        .i_addr      (w_addr),
        .i_t         (r_t),
        .i_node_rd   (r_node_rd),
        .i_work_rd   (r_work_rd),
        .o_wr        (w_wr),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // ---- output register -------------------------------------------------
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.point_x = r_out.x;
    assign o_out.point_y = r_out.y;

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !i_in.ready)
        else $error("evaluate word did not start the sequencer");

    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> !w_idle)
        else $error("work memory written while idle");

endmodule
